FILE: sv/tlpws_pkg.sv
// Shared types and constants for the three-level priority work scheduler.
// No dependencies; imported by three_level_priority_work_scheduler.
package tlpws_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int DEFAULT_TAG_BITS    = 16;

	localparam int RATIO_W       = 8;
	localparam int SERVED_TAG_W  = 16;
	localparam int PENDING_W     = 6;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd4;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	localparam logic [1:0] CLS_HIGH = 2'd0;
	localparam logic [1:0] CLS_MED  = 2'd1;
	localparam logic [1:0] CLS_LOW  = 2'd2;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_FULL   = 2'd1,
		ST_POPPED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

endpackage

FILE: sv/three_level_priority_work_scheduler.sv
// Three-level priority work scheduler: high, medium and low tag FIFOs with a
// medium-to-low service ratio. Depends on tlpws_pkg.
//
// Push items put a tag into the FIFO of their class (class three counts as
// low) or come back flagged full; pop items hand out a tag, high first, then
// medium, letting one low tag through each time the run of medium services
// reaches medium_to_low_ratio. Every item gives exactly one result item. The
// block takes one item per cycle when the output side keeps up; an accepted
// item passes through the input register, then the result register, where its
// result is presented until taken. The rate is set by the queue update: each
// FIFO keeps its head tag in a register that is prefetched from its memory at
// the next read pointer, with a bypass when a push lands in an empty FIFO, so
// a pop never waits on a memory read. Write medium_to_low_ratio only while the
// block is idle; it resets to 4. There is no clearing pass after reset.
module three_level_priority_work_scheduler
	import tlpws_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
	parameter int TAG_BITS    = DEFAULT_TAG_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr_en,
	input  logic [RATIO_W-1:0]      cfg_wr_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic [1:0]              priority_class,
	input  logic [TAG_BITS-1:0]     work_tag,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [SERVED_TAG_W-1:0] served_tag,
	output logic [1:0]              served_class,
	output logic [PENDING_W-1:0]    pending_total
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = (CNT_W + 2 > PENDING_W) ? CNT_W + 2 : PENDING_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// ---------------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------------
	logic [RATIO_W-1:0] ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_wr_en) begin
			ratio_q <= cfg_wr_data;
		end
	end

	// ---------------------------------------------------------------------
	// Handshake: input register (s1) feeds result register (s2).
	// s1 advances whenever s2 is empty or its item is being taken.
	// ---------------------------------------------------------------------
	logic                valid_s1;
	op_t                 op_s1;
	logic [1:0]          cls_s1;
	logic [TAG_BITS-1:0] tag_s1;

	logic                valid_s2;
	status_t             status_s2;
	logic [SERVED_TAG_W-1:0] tag_s2;
	logic [1:0]          cls_s2;
	logic [PENDING_W-1:0] pending_s2;

	logic advance;
	logic in_accept;
	logic s1_fire;

	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign s1_fire   = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input register: load on accept only
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1  <= op_t'(operation);
			cls_s1 <= priority_class;
			tag_s1 <= work_tag;
		end
	end

	// ---------------------------------------------------------------------
	// Queue state
	// ---------------------------------------------------------------------
	logic [2:0][PTR_W-1:0]    rp_q;
	logic [2:0][PTR_W-1:0]    wp_q;
	logic [2:0][CNT_W-1:0]    cnt_q;
	logic [2:0][TAG_BITS-1:0] head_q;
	logic [RATIO_W-1:0]       svc_q;

	logic [2:0][PTR_W-1:0]    rp_next;
	logic [2:0][PTR_W-1:0]    wp_next;
	logic [2:0][CNT_W-1:0]    cnt_next;
	logic [RATIO_W-1:0]       svc_next;

	logic [2:0] nonempty;
	logic [2:0] full;
	logic [2:0] push_en;
	logic [2:0] pop_en;
	logic [1:0] push_idx;
	logic [1:0] pop_sel;
	logic       pop_ok;
	status_t    status_next;
	logic [SUM_W-1:0] pending_sum;

	// class three is stored as low
	always_comb begin
		case (cls_s1)
			CLS_HIGH: push_idx = CLS_HIGH;
			CLS_MED:  push_idx = CLS_MED;
			default:  push_idx = CLS_LOW;
		endcase
	end

	// Pop arbitration: high first; medium until the service run reaches the
	// ratio, then one low tag (if any) and restart the run; low last.
	always_comb begin
		for (int g = 0; g < 3; g++) begin
			nonempty[g] = (cnt_q[g] != '0);
			full[g]     = (cnt_q[g] == CNT_FULL);
		end
		pop_ok   = 1'b1;
		pop_sel  = CLS_HIGH;
		svc_next = svc_q;
		if (nonempty[CLS_HIGH]) begin
			pop_sel = CLS_HIGH;
		end else if (nonempty[CLS_MED]) begin
			if (svc_q >= ratio_q) begin
				pop_sel  = nonempty[CLS_LOW] ? CLS_LOW : CLS_MED;
				svc_next = '0;
			end else begin
				pop_sel  = CLS_MED;
				svc_next = svc_q + RATIO_W'(1);
			end
		end else if (nonempty[CLS_LOW]) begin
			pop_sel = CLS_LOW;
		end else begin
			pop_ok = 1'b0;
		end
	end

	always_comb begin
		if (op_s1 == OP_PUSH) begin
			status_next = full[push_idx] ? ST_FULL : ST_PUSHED;
		end else begin
			status_next = pop_ok ? ST_POPPED : ST_EMPTY;
		end
	end

	// per-queue enables, pointer and count updates
	always_comb begin
		for (int g = 0; g < 3; g++) begin
			push_en[g] = s1_fire && (op_s1 == OP_PUSH) && (push_idx == 2'(g)) && !full[g];
			pop_en[g]  = s1_fire && (op_s1 == OP_POP) && pop_ok && (pop_sel == 2'(g));

			rp_next[g] = rp_q[g];
			if (pop_en[g]) begin
				rp_next[g] = (rp_q[g] == PTR_LAST) ? '0 : rp_q[g] + PTR_W'(1);
			end
			wp_next[g] = wp_q[g];
			if (push_en[g]) begin
				wp_next[g] = (wp_q[g] == PTR_LAST) ? '0 : wp_q[g] + PTR_W'(1);
			end

			if (push_en[g]) begin
				cnt_next[g] = cnt_q[g] + CNT_W'(1);
			end else if (pop_en[g]) begin
				cnt_next[g] = cnt_q[g] - CNT_W'(1);
			end else begin
				cnt_next[g] = cnt_q[g];
			end
		end
		pending_sum = SUM_W'(cnt_next[0]) + SUM_W'(cnt_next[1]) + SUM_W'(cnt_next[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
			svc_q <= '0;
		end else begin
			rp_q  <= rp_next;
			wp_q  <= wp_next;
			cnt_q <= cnt_next;
			// the run counter moves only on pops that reach the medium test
			if (s1_fire && (op_s1 == OP_POP) && !nonempty[CLS_HIGH] && nonempty[CLS_MED]) begin
				svc_q <= svc_next;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tag memories, one per class. Each cycle prefetch the entry at the next
	// read pointer into the head register; bypass a push into an empty FIFO.
	// ---------------------------------------------------------------------
	for (genvar g = 0; g < 3; g++) begin : g_fifo
		logic [TAG_BITS-1:0] mem_q [QUEUE_DEPTH];

		always_ff @(posedge clk) begin
			if (push_en[g]) begin
				mem_q[wp_q[g]] <= tag_s1;
			end
			if (push_en[g] && (wp_q[g] == rp_next[g])) begin
				head_q[g] <= tag_s1;
			end else begin
				head_q[g] <= mem_q[rp_next[g]];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_s2  <= status_next;
			pending_s2 <= pending_sum[PENDING_W-1:0];
			if (status_next == ST_POPPED) begin
				tag_s2 <= SERVED_TAG_W'(head_q[pop_sel]);
				cls_s2 <= pop_sel;
			end else begin
				tag_s2 <= '0;
				cls_s2 <= CLS_HIGH;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign status        = status_s2;
	assign served_tag    = tag_s2;
	assign served_class  = cls_s2;
	assign pending_total = pending_s2;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CNT_FULL) && (cnt_q[1] <= CNT_FULL) && (cnt_q[2] <= CNT_FULL))
		else $error("queue count above depth");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with an empty input register");

	a_empty_pop_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && (op_s1 == OP_POP) && !pop_ok) |=> ($stable(cnt_q) && $stable(svc_q)))
		else $error("pop on empty queues changed state");

	a_ratio_low_restarts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && (op_s1 == OP_POP) && !nonempty[CLS_HIGH] && nonempty[CLS_MED]
			&& (pop_sel == CLS_LOW)) |=> (svc_q == '0))
		else $error("low service by ratio did not clear the run counter");

	a_push_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ((status_s2 == ST_PUSHED) || (status_s2 == ST_FULL)))
			|-> ((tag_s2 == '0) && (cls_s2 == CLS_HIGH)))
		else $error("push result carries a served tag");
`endif

endmodule
